[rtl/core/rdc_pkg.sv]
// ============================================================================
// rdc_pkg: shared types, constants and microprogram of the radix converter
// Holds the control word layout, the step codes of the microprogram, the
// divider control and status groups, and the digit and base helpers.
// ============================================================================
`default_nettype none

package rdc_pkg;

  // Field widths fixed by the interface.
  localparam int VALUE_W   = 31;
  localparam int BASE_W    = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 7;

  // Configuration register map.
  localparam int CFG_AW                    = 3;
  localparam logic [CFG_AW-1:0] CFG_BASE_ADDR = 3'd0;

  // Base limits and reset value.
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  // Digit to character mapping.
  localparam logic [CHAR_W-1:0] ASCII_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_OFS = 7'd55;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT      = 6'd10;

  // Long division: the dividend is padded to a whole number of chunks and
  // DIV_BITS quotient bits are produced per cycle.
  localparam int DVD_W      = 32;
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = DVD_W / DIV_BITS;
  localparam int CYC_W      = $clog2(DIV_CYCLES);

  // Microprogram step codes.
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] ST_IDLE = 3'd0;
  localparam logic [PC_W-1:0] ST_DIV  = 3'd1;
  localparam logic [PC_W-1:0] ST_PUSH = 3'd2;
  localparam logic [PC_W-1:0] ST_POP  = 3'd3;
  localparam logic [PC_W-1:0] ST_EMIT = 3'd4;

  // Jump condition codes.
  localparam logic [2:0] JC_NEVER    = 3'd0;
  localparam logic [2:0] JC_NO_START = 3'd1;
  localparam logic [2:0] JC_DIV_MORE = 3'd2;
  localparam logic [2:0] JC_QUOT_NZ  = 3'd3;
  localparam logic [2:0] JC_STACK_NZ = 3'd4;

  typedef struct packed {
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic            fall_idle;
    logic            load;
    logic            div_step;
    logic            push;
    logic            pop;
    logic            emit;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
    logic restart;
  } div_ctl_t;

  typedef struct packed {
    logic               last_cycle;
    logic               quot_nz;
    logic [DIGIT_W-1:0] rem;
  } div_sts_t;

  // Control store. A taken jump goes to target; otherwise the sequencer
  // moves to the next step, or back to idle when fall_idle is set.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      ST_IDLE: begin
        w.cond   = JC_NO_START;
        w.target = ST_IDLE;
        w.load   = 1'b1;
      end
      ST_DIV: begin
        w.cond     = JC_DIV_MORE;
        w.target   = ST_DIV;
        w.div_step = 1'b1;
      end
      ST_PUSH: begin
        w.cond   = JC_QUOT_NZ;
        w.target = ST_DIV;
        w.push   = 1'b1;
      end
      ST_POP: begin
        w.cond   = JC_NEVER;
        w.target = ST_IDLE;
        w.pop    = 1'b1;
      end
      ST_EMIT: begin
        w.cond      = JC_STACK_NZ;
        w.target    = ST_EMIT;
        w.fall_idle = 1'b1;
        w.pop       = 1'b1;
        w.emit      = 1'b1;
      end
      default: begin
        w.cond      = JC_NEVER;
        w.target    = ST_IDLE;
        w.fall_idle = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = ASCII_ZERO + {1'b0, d};
    end else begin
      c = ASCII_ALPHA_OFS + {1'b0, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rdc_divider.sv]
// ============================================================================
// rdc_divider: chunked long division of the value by the base
// Holds dividend, partial remainder and chunk counter; each step retires
// DIV_BITS quotient bits, leaving the quotient in place of the dividend.
// ============================================================================
`default_nettype none

module rdc_divider
  import rdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire div_ctl_t           ctl,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [BASE_W-1:0]  base,
  output div_sts_t                sts
);

  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [BASE_W-1:0]  base_r;
  logic [CYC_W-1:0]   cyc_r, cyc_nxt;

  logic [DIGIT_W-1:0] r_step;
  logic [DIV_BITS-1:0] q_step;

  // Radix-2 restoring steps on the narrow remainder; it stays below base.
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W:0] diff;
    r_step = rem_r;
    q_step = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t    = {r_step, dvd_r[DVD_W-1-i]};
      diff = t - {1'b0, base_r};
      if (t >= {1'b0, base_r}) begin
        r_step              = diff[DIGIT_W-1:0];
        q_step[DIV_BITS-1-i] = 1'b1;
      end else begin
        r_step = t[DIGIT_W-1:0];
      end
    end
  end

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cyc_nxt = cyc_r;
    if (ctl.load) begin
      dvd_nxt = {{(DVD_W-VALUE_W){1'b0}}, value};
      rem_nxt = '0;
      cyc_nxt = '0;
    end else if (ctl.step) begin
      dvd_nxt = {dvd_r[DVD_W-DIV_BITS-1:0], q_step};
      rem_nxt = r_step;
      cyc_nxt = cyc_r + 1'b1;
    end else if (ctl.restart) begin
      rem_nxt = '0;
      cyc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r <= '0;
    end else begin
      cyc_r <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (ctl.load) begin
      base_r <= eff_base(base);
    end
  end

  assign sts.last_cycle = (cyc_r == CYC_W'(DIV_CYCLES - 1));
  assign sts.quot_nz    = (dvd_r != '0);
  assign sts.rem        = rem_r;

endmodule

`default_nettype wire

[rtl/core/radix_digit_converter.sv]
// ============================================================================
// radix_digit_converter: integer to base-N character string converter
// Converts one non-negative integer to the configured base and emits its digits
// most significant first as ASCII characters with group and last marks.
// ============================================================================
//
// A transaction is accepted on a rising edge with start high and busy low.
// The value is divided repeatedly by the base held in the base register
// (byte address 0; values below 2 act as 2, above 36 act as 36), and each
// remainder is pushed onto an internal digit stack. The stack is then popped
// and one result transaction is presented per digit, most significant
// first, for exactly one cycle with out_strobe high; the receiver cannot
// stall, so results must be taken as they come. The block stays busy until
// the final digit of a value has been emitted and takes no new value before
// then. A result has at most 31 digits, in binary. For every digit the
// divider retires four quotient bits per cycle over every chunk of the
// dividend and one push step follows; after the last digit come one pop
// step and then one emission step per digit. Digits appear on the output
// in the cycle after the sequencer emits them, so the final digit may
// overlap the first cycle in which busy is low again. out_group_end is set
// when the number of digits still to come is a multiple of four (always on
// the final digit), and out_last marks the final digit. The base register
// may only be written while no conversion is in flight.
//
`default_nettype none

module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int DIGIT_DEPTH = 32
)(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input transaction
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [VALUE_W-1:0] in_value,
  // Result transaction
  output logic                    out_strobe,
  output logic [CHAR_W-1:0]       out_digit_char,
  output logic                    out_group_end,
  output logic                    out_last,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [CFG_AW-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] base_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == CFG_BASE_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_wr) begin
      base_r <= pwdata[BASE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == CFG_BASE_ADDR) begin
      prdata = {{(32-BASE_W){1'b0}}, base_r};
    end
  end

  // --------------------------------------------------------------------------
  // Microcode sequencer
  // --------------------------------------------------------------------------
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;
  logic            jump;
  div_ctl_t        div_ctl;
  div_sts_t        div_sts;
  logic [CW-1:0]   count_r, count_nxt;

  assign uw   = ucode(pc_r);
  assign busy = (pc_r != ST_IDLE);

  always_comb begin
    case (uw.cond)
      JC_NEVER:    jump = 1'b0;
      JC_NO_START: jump = !start;
      JC_DIV_MORE: jump = !div_sts.last_cycle;
      JC_QUOT_NZ:  jump = div_sts.quot_nz;
      JC_STACK_NZ: jump = (count_r != '0);
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_nxt = uw.target;
    end else if (uw.fall_idle) begin
      pc_nxt = ST_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider
  // --------------------------------------------------------------------------
  assign div_ctl.load    = uw.load && start;
  assign div_ctl.step    = uw.div_step;
  assign div_ctl.restart = uw.push;

  rdc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .value (in_value),
    .base  (base_r),
    .sts   (div_sts)
  );

  // --------------------------------------------------------------------------
  // Digit stack. Remainders go in least significant first; popping reads
  // them back most significant first. Reads are registered, so a pop issued
  // in one cycle delivers its digit for emission in the next.
  // --------------------------------------------------------------------------
  logic [DIGIT_W-1:0] stack_mem [DIGIT_DEPTH];
  logic [DIGIT_W-1:0] rd_data_r;
  logic [CW-1:0]      count_m1;
  logic               push_en;
  logic               pop_en;

  assign count_m1 = count_r - 1'b1;
  // Digits beyond the stack depth are dropped.
  assign push_en  = uw.push && (count_r < CW'(DIGIT_DEPTH));
  assign pop_en   = uw.pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push_en) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_en) begin
      count_nxt = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[count_r[AW-1:0]] <= div_sts.rem;
    end
    if (pop_en) begin
      rd_data_r <= stack_mem[count_m1[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Result register. While emitting, count_r holds the number of digits
  // still to come after the one being presented.
  // --------------------------------------------------------------------------
  logic              out_strobe_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_group_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= uw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit) begin
      out_char_r  <= digit_to_ascii(rd_data_r);
      out_group_r <= (count_r[1:0] == 2'b00);
      out_last_r  <= (count_r == '0);
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_digit_char = out_char_r;
  assign out_group_end  = out_group_r;
  assign out_last       = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DIGIT_DEPTH))
    else $error("digit stack count beyond depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (count_r == '0))
    else $error("digit stack not empty while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start a conversion");

  a_digits_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("gap in digit stream before last digit");

  a_last_grouped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> out_group_end)
    else $error("final digit without group mark");

endmodule

`default_nettype wire
